// ===== rtl/singleton_hold_release_tracker_macros.svh =====
// Assertion helpers; clk and rst must be in scope where they are used.
`ifndef SINGLETON_HOLD_RELEASE_TRACKER_MACROS_SVH
`define SINGLETON_HOLD_RELEASE_TRACKER_MACROS_SVH

// Same-cycle implication.
`define SHRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SHRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/shrt_pkg.sv =====
package shrt_pkg;

  localparam int KEY_W = 6;
  localparam int JOB_W = 64;
  localparam int ACT_W = 16;

  typedef enum logic [1:0] {
    CMD_REQUEST  = 2'd0,
    CMD_ACTIVE   = 2'd1,
    CMD_INACTIVE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_COUNTED   = 3'd0,
    ST_RELEASED  = 3'd1,
    ST_HELD      = 3'd2,
    ST_NO_NAME   = 3'd3,
    ST_POOL_FULL = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key_slot;
    logic             has_name;
    logic [JOB_W-1:0] job_id;
  } req_item_t;

  typedef struct packed {
    status_t          status;
    logic             release_valid;
    logic [JOB_W-1:0] release_job;
    logic [ACT_W-1:0] active_after;
  } rsp_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_DEC,
    S_FIND,
    S_RM,
    S_SHIFT,
    S_CNT,
    S_REL,
    S_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    mod_step;
    logic    clr_step;
    logic    cnt_load;
    logic    status_set;
    status_t status;
    logic    append;
    logic    scan;
    logic    scan_init;
    logic    held_inc;
    logic    take_first;
    logic    ptr_load;
    logic    shift;
    logic    total_dec;
    logic    rel_load;
    logic    cnt_write;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       named;
    logic       slot_big;
    logic       cnt_zero;
    logic       pool_full;
    logic       empty;
    logic       qlive;
    logic       slot_hit;
    logic       job_hit;
    logic       last;
    logic       first_valid;
    logic       first_last;
    logic       rel_ok;
    logic       clr_last;
  } dp_sts_t;

endpackage

// ===== rtl/shrt_dp.sv =====
module shrt_dp #(
  parameter int KEY_SLOTS   = 64,
  parameter int HOLD_SLOTS  = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  shrt_pkg::dp_cmd_t   cmd,
  output shrt_pkg::dp_sts_t   sts,
  input  shrt_pkg::req_item_t req_item,
  output shrt_pkg::rsp_item_t rsp_item
);
  import shrt_pkg::*;

  localparam int SW = $clog2(KEY_SLOTS);
  localparam int PW = $clog2(HOLD_SLOTS);
  localparam int TW = $clog2(HOLD_SLOTS + 1);
  localparam logic [KEY_W-1:0] KEY_STEP = KEY_W'(KEY_SLOTS % (2 ** KEY_W));

  logic [1:0]             command;
  logic                   named;
  logic [KEY_W-1:0]       red;
  logic [JOB_W-1:0]       job;
  logic [SW-1:0]          slot;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_next;
  logic [COUNT_WIDTH-1:0] cnt_q;
  status_t                status;
  logic                   rel_valid;
  logic [JOB_W-1:0]       rel_job;
  logic [TW-1:0]          total;
  logic [TW-1:0]          ptr;
  logic [PW-1:0]          qidx;
  logic                   qlive;
  logic [SW-1:0]          q_slot;
  logic [JOB_W-1:0]       q_job;
  logic [TW-1:0]          held;
  logic                   first_valid;
  logic [PW-1:0]          first_idx;
  logic [JOB_W-1:0]       first_job;
  logic [SW-1:0]          cidx;
  rsp_item_t              rsp;

  logic [COUNT_WIDTH-1:0] cnt_mem   [KEY_SLOTS];
  logic [SW-1:0]          pool_slot [HOLD_SLOTS];
  logic [JOB_W-1:0]       pool_job  [HOLD_SLOTS];

  assign slot = SW'(red);

  always_comb begin
    cnt_next = cnt_q;
    if (named && command == CMD_ACTIVE && !(&cnt_q)) begin
      cnt_next = cnt_q + 1'b1;
    end else if (named && command == CMD_INACTIVE && cnt_q != '0) begin
      cnt_next = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total       <= '0;
      qlive       <= 1'b0;
      cidx        <= '0;
      first_valid <= 1'b0;
    end else begin
      qlive <= cmd.scan && (ptr < total);
      if (cmd.clr_step) begin
        cidx <= cidx + 1'b1;
      end
      if (cmd.append) begin
        total <= total + 1'b1;
      end else if (cmd.total_dec) begin
        total <= total - 1'b1;
      end
      if (cmd.scan_init) begin
        first_valid <= 1'b0;
      end else if (cmd.take_first) begin
        first_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      command   <= req_item.command;
      named     <= req_item.has_name;
      red       <= req_item.key_slot;
      job       <= req_item.job_id;
      rel_valid <= 1'b0;
      rel_job   <= '0;
    end else if (cmd.mod_step) begin
      red <= red - KEY_STEP;
    end else if (cmd.rel_load) begin
      rel_valid <= 1'b1;
      rel_job   <= first_job;
    end
    if (cmd.load_in) begin
      status <= ST_COUNTED;
    end else if (cmd.status_set) begin
      status <= cmd.status;
    end
    if (cmd.cnt_load) begin
      cnt <= cnt_next;
    end
    if (cmd.scan_init) begin
      ptr  <= '0;
      held <= '0;
    end else begin
      if (cmd.ptr_load) begin
        ptr <= TW'(first_idx) + 1'b1;
      end else if (cmd.scan) begin
        ptr <= ptr + 1'b1;
      end
      if (cmd.held_inc) begin
        held <= held + 1'b1;
      end
    end
    qidx <= ptr[PW-1:0];
    if (cmd.take_first) begin
      first_idx <= qidx;
      first_job <= q_job;
    end
    if (cmd.out_load) begin
      rsp.status        <= status;
      rsp.release_valid <= rel_valid;
      rsp.release_job   <= rel_job;
      rsp.active_after  <= ACT_W'(cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      cnt_mem[cidx] <= '0;
    end else if (cmd.cnt_write) begin
      cnt_mem[slot] <= cnt;
    end
    cnt_q <= cnt_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      pool_slot[total[PW-1:0]] <= slot;
      pool_job[total[PW-1:0]]  <= job;
    end else if (cmd.shift && qlive) begin
      pool_slot[qidx - 1'b1] <= q_slot;
      pool_job[qidx - 1'b1]  <= q_job;
    end
    q_slot <= pool_slot[ptr[PW-1:0]];
    q_job  <= pool_job[ptr[PW-1:0]];
  end

  assign sts.command     = command;
  assign sts.named       = named;
  assign sts.slot_big    = (red >= KEY_SLOTS);
  assign sts.cnt_zero    = (cnt_q == '0);
  assign sts.pool_full   = (total == TW'(HOLD_SLOTS));
  assign sts.empty       = (total == '0);
  assign sts.qlive       = qlive;
  assign sts.slot_hit    = (q_slot == slot);
  assign sts.job_hit     = (q_job == job);
  assign sts.last        = (TW'(qidx) == total - 1'b1);
  assign sts.first_valid = first_valid;
  assign sts.first_last  = (TW'(first_idx) == total - 1'b1);
  assign sts.rel_ok      = (held != '0) && (cnt == held);
  assign sts.clr_last    = (cidx == SW'(KEY_SLOTS - 1));

  assign rsp_item = rsp;

endmodule

// ===== rtl/shrt_ctrl.sv =====
`include "singleton_hold_release_tracker_macros.svh"

module shrt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output shrt_pkg::dp_cmd_t cmd,
  input  shrt_pkg::dp_sts_t sts
);
  import shrt_pkg::*;

  state_t state;
  state_t state_next;
  logic   to_wr;
  logic   to_wr_next;
  logic   rsp_free;
  logic   hit;

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      to_wr     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      to_wr <= to_wr_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    to_wr_next = to_wr;
    hit        = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.slot_big) begin
          cmd.mod_step = 1'b1;
        end else begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.cnt_load = 1'b1;
        state_next   = S_DONE;
        if (sts.command == CMD_REQUEST) begin
          cmd.status_set = 1'b1;
          if (!sts.named) begin
            cmd.status = ST_NO_NAME;
          end else if (sts.cnt_zero) begin
            cmd.status = ST_RELEASED;
          end else if (sts.pool_full) begin
            cmd.status = ST_POOL_FULL;
          end else begin
            cmd.status = ST_HELD;
            cmd.append = 1'b1;
          end
        end else if (sts.named && sts.command == CMD_ACTIVE) begin
          cmd.scan_init = 1'b1;
          state_next    = S_CNT;
        end else if (sts.named && sts.command == CMD_INACTIVE) begin
          cmd.scan_init = 1'b1;
          state_next    = S_FIND;
        end
      end
      S_FIND: begin
        hit = sts.qlive && sts.slot_hit && sts.job_hit;
        if (sts.empty || (sts.qlive && sts.last && !hit)) begin
          cmd.scan_init = 1'b1;
          state_next    = S_CNT;
        end else if (hit) begin
          cmd.take_first = 1'b1;
          to_wr_next     = 1'b0;
          state_next     = S_RM;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_RM: begin
        if (sts.first_last) begin
          cmd.total_dec = 1'b1;
          if (to_wr) begin
            state_next = S_WR;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = S_CNT;
          end
        end else begin
          cmd.ptr_load = 1'b1;
          state_next   = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.qlive && sts.last) begin
          cmd.total_dec = 1'b1;
          if (to_wr) begin
            state_next = S_WR;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = S_CNT;
          end
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_CNT: begin
        hit = sts.qlive && sts.slot_hit;
        if (hit) begin
          cmd.held_inc   = 1'b1;
          cmd.take_first = !sts.first_valid;
        end
        if (sts.empty || (sts.qlive && sts.last)) begin
          state_next = S_REL;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_REL: begin
        if (sts.rel_ok) begin
          cmd.rel_load = 1'b1;
          to_wr_next   = 1'b1;
          state_next   = S_RM;
        end else begin
          state_next = S_WR;
        end
      end
      S_WR: begin
        cmd.cnt_write = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (rsp_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `SHRT_ASSERT_NOW(a_load_free, cmd.out_load, (!rsp_valid || !rsp_stall), "result overwritten")
  `SHRT_ASSERT_NOW(a_append_room, cmd.append, !sts.pool_full, "append into full hold pool")
  `SHRT_ASSERT_NOW(a_drop_nonempty, cmd.total_dec, !sts.empty, "removal from empty hold pool")
  `SHRT_ASSERT_NOW(a_release_found, cmd.rel_load, sts.first_valid, "release without held job")
  `SHRT_ASSERT_NEXT(a_accept_start, (req_valid && !req_stall), (state == S_MOD), "item not started")

endmodule

// ===== rtl/singleton_hold_release_tracker.sv =====
// channel  dir  handshake              payload
// req      in   req_valid / req_stall  shrt_pkg::req_item_t (command, key_slot, has_name, job_id)
// rsp      out  rsp_valid / rsp_stall  shrt_pkg::rsp_item_t (status, release_*, active_after)
//
// One item at a time. Slot reduction comes first; a request or an ignored event then needs no
// pass over the hold pool. A named active event makes one pass over the hold pool; an inactive
// event makes up to two passes plus gap closing, all bound by the single read port of the pool.
// After reset the count store is cleared with req_stall high.
// A result waits in the output register; the next item is taken while it waits.
module singleton_hold_release_tracker #(
  parameter int KEY_SLOTS   = 64,
  parameter int HOLD_SLOTS  = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  shrt_pkg::req_item_t req_item,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output shrt_pkg::rsp_item_t rsp_item
);
  import shrt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  shrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  shrt_dp #(
    .KEY_SLOTS   (KEY_SLOTS),
    .HOLD_SLOTS  (HOLD_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .req_item (req_item),
    .rsp_item (rsp_item)
  );

endmodule
